@@ hdl/p_square_quantile_estimator_macros.svh @@
// assertion macros for the p-square quantile estimator
// used by p_square_quantile_estimator.sv, no other dependencies
`ifndef P_SQUARE_QUANTILE_ESTIMATOR_MACROS_SVH
`define P_SQUARE_QUANTILE_ESTIMATOR_MACROS_SVH
`ifndef SYNTH
`define PSQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("p-square check failed");
`define PSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("p-square check failed");
`else
`define PSQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/psq_pkg.sv @@
// shared types and constants for the p-square quantile estimator
// no dependencies
`default_nettype none
package psq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 32;
    localparam int POSITION_WIDTH_DEF = 32;

    localparam int INC_W   = 17;
    localparam int START_W = 19;
    localparam int CFG_W   = 19;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INC_LOWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_MIDDLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INC_UPPER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_MIDDLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_UPPER  = 3'd5;

    localparam logic [INC_W-1:0]   INC_LOWER_RST    = 17'd16384;
    localparam logic [INC_W-1:0]   INC_MIDDLE_RST   = 17'd32768;
    localparam logic [INC_W-1:0]   INC_UPPER_RST    = 17'd49152;
    localparam logic [START_W-1:0] START_LOWER_RST  = 19'd65536;
    localparam logic [START_W-1:0] START_MIDDLE_RST = 19'd131072;
    localparam logic [START_W-1:0] START_UPPER_RST  = 19'd196608;

    typedef enum logic { OP_MUL, OP_DIV } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               batch_end;
    } sample_word_t;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic               warmed_up;
        logic               saturated;
    } result_word_t;

endpackage
`default_nettype wire

@@ hdl/psq_arith.sv @@
// shared bit-serial multiply / restoring divide unit, one bit per cycle
// depends on psq_pkg
`default_nettype none
module psq_arith
    import psq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int NW = POSITION_WIDTH + SAMPLE_WIDTH + 2
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire arith_req_t                req,
    input  wire logic [NW-1:0]             opa,
    input  wire logic [POSITION_WIDTH-1:0] opb,
    output logic                           done,
    output logic [NW-1:0]                  result
);

    localparam int PW   = POSITION_WIDTH;
    localparam int CNTW = $clog2(NW + 1);

    typedef enum logic { A_IDLE, A_RUN } astate_t;

    astate_t         state_reg;
    arith_op_t       op_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   acc_reg;
    logic [NW-1:0]   sh_reg;
    logic [PW-1:0]   rem_reg;
    logic [PW-1:0]   den_reg;
    logic            done_reg;

    logic [PW:0]     rshift;
    logic [NW-1:0]   add_x;
    logic [NW-1:0]   add_y;
    logic            add_cin;
    logic [NW:0]     add_sum;

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        rshift = {rem_reg, sh_reg[NW-1]};
        if (op_reg == OP_MUL)
        begin
            add_x   = acc_reg;
            add_y   = sh_reg;
            add_cin = 1'b0;
        end
        else
        begin
            add_x   = NW'(rshift);
            add_y   = ~NW'(den_reg);
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + (NW+1)'(add_cin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= OP_MUL;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            sh_reg    <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        acc_reg <= '0;
                        sh_reg  <= opa;
                        if (req.op == OP_MUL)
                        begin
                            rem_reg   <= opb;
                            cnt_reg   <= CNTW'(PW);
                            state_reg <= A_RUN;
                        end
                        else
                        begin
                            rem_reg <= '0;
                            den_reg <= opb;
                            cnt_reg <= CNTW'(NW);
                            // zero divisor gives a zero quotient at once
                            if (opb == '0)
                                done_reg <= 1'b1;
                            else
                                state_reg <= A_RUN;
                        end
                    end
                end
                A_RUN:
                begin
                    if (op_reg == OP_MUL)
                    begin
                        if (rem_reg[0])
                            acc_reg <= add_sum[NW-1:0];
                        sh_reg  <= {sh_reg[NW-2:0], 1'b0};
                        rem_reg <= {1'b0, rem_reg[PW-1:1]};
                    end
                    else
                    begin
                        acc_reg <= {acc_reg[NW-2:0], add_sum[NW]};
                        sh_reg  <= {sh_reg[NW-2:0], 1'b0};
                        rem_reg <= add_sum[NW] ? add_sum[PW-1:0] : rshift[PW-1:0];
                    end
                    cnt_reg <= cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                    state_reg <= A_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

@@ hdl/p_square_quantile_estimator.sv @@
// p-square streaming quantile estimator: marker state, sequencer, config registers
// depends on psq_pkg, psq_arith and p_square_quantile_estimator_macros.svh
//
// channel  direction  handshake                     payload
// sample   in         sample_valid / sample_stall   sample_word_t
// result   out        result_valid / result_stall   result_word_t
// config   in         cfg_wr_en                     cfg_index, cfg_data
//
// warm-up samples go from S_IDLE to S_PREP and, with a result word, S_EMIT; later
// samples also visit S_CHECK per inner marker, and for each inner marker that moves
// run a test state, two multiplies and three or four divides on the shared unit
// a result word sits in an output register; the next sample is taken while it waits
// reset clears markers positions to 0..4 and loads the desired positions
`default_nettype none
`include "p_square_quantile_estimator_macros.svh"
module p_square_quantile_estimator
    import psq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire sample_word_t         sample_word,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_word_t              result_word,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int PW  = POSITION_WIDTH;
    localparam int NW  = PW + SW + 2;
    localparam int DPW = PW + 16;
    localparam int EW  = (NW > 64) ? NW : 64;
    localparam logic [EW-1:0] CLAMP_E = EW'(64'h4000_0000_0000_0000);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CHECK, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_DIV3,
        S_TEST, S_LIN, S_EMIT
    } state_t;

    function automatic logic [PW-1:0] pdiff(logic [PW-1:0] a, logic [PW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SW:0] hmag(logic signed [SW:0] v);
        return v[SW] ? $unsigned(-v) : $unsigned(v);
    endfunction

    // registers
    state_t                state_reg, state_next;
    logic signed [SW-1:0]  h_reg [5];
    logic signed [SW-1:0]  h_next [5];
    logic [PW-1:0]         pos_reg [5];
    logic [PW-1:0]         pos_next [5];
    logic [DPW-1:0]        des_reg [3];
    logic [DPW-1:0]        des_next [3];
    logic [INC_W-1:0]      inc_reg [3];
    logic [START_W-1:0]    start_reg [3];
    logic [2:0]            cnt_reg, cnt_next;
    logic                  sat_reg, sat_next;
    logic [1:0]            k_reg, k_next;
    logic                  up_reg, up_next;
    logic [PW-1:0]         n_reg, n_next;
    logic                  pend_reg, pend_next;
    logic signed [SW-1:0]  x_reg, x_next;
    logic                  batch_reg, batch_next;
    logic [NW-1:0]         prod_reg, prod_next;
    logic [NW-1:0]         t1_reg, t1_next;
    logic                  t1neg_reg, t1neg_next;
    logic [NW-1:0]         s_reg, s_next;
    logic                  sneg_reg, sneg_next;
    logic [NW-1:0]         q3_reg, q3_next;
    logic                  rv_reg, rv_next;
    result_word_t          rw_reg, rw_next;

    // marker neighborhood of the current inner marker
    logic [2:0]            kk, km, kp;
    logic [PW-1:0]         ml, m, mh, nm;
    logic [PW:0]           np;
    logic [DPW-1:0]        f;
    logic signed [SW-1:0]  ql, q, qh;
    logic signed [SW:0]    hda, hdb;
    logic                  mvup, mvdn;
    logic [PW-1:0]         pa, pb, d1, d2, d3;

    // shared unit
    arith_req_t            areq;
    logic [NW-1:0]         aopa;
    logic [PW-1:0]         aopb;
    logic                  adone;
    logic [NW-1:0]         ares;

    // comb temporaries
    logic [2:0]            ins_pos;
    logic [2:0]            first;
    logic [DPW:0]          dsum;
    logic [EW-1:0]         qe;
    logic [62:0]           cmag;
    logic signed [63:0]    qt, newp, q64, ql64, qh64;
    logic [SW:0]           quo;
    logic                  lsgn;
    logic signed [SW+1:0]  lq, newl;
    logic signed [63:0]    est_ext;

    always_comb
    begin
        kk = {1'b0, k_reg};
        km = kk - 3'd1;
        kp = kk + 3'd1;
        ml = pos_reg[km];
        m  = pos_reg[kk];
        mh = pos_reg[kp];
        ql = h_reg[km];
        q  = h_reg[kk];
        qh = h_reg[kp];
        f  = des_reg[k_reg - 2'd1];
        np = {1'b0, m} + (PW+1)'(1);
        nm = m - PW'(1);
        mvup = ({1'b0, mh} > np) && ({1'b0, f} >= {np, 16'h0});
        mvdn = (({1'b0, ml} + (PW+1)'(1)) < {1'b0, m}) && (f <= {nm, 16'h0});
        hda = $signed({qh[SW-1], qh}) - $signed({q[SW-1], q});
        hdb = $signed({q[SW-1], q}) - $signed({ql[SW-1], ql});
        pa = pdiff(n_reg, ml);
        pb = pdiff(mh, n_reg);
        d1 = pdiff(mh, m);
        d2 = pdiff(m, ml);
        d3 = pdiff(mh, ml);
    end

    // operand steering into the shared unit
    always_comb
    begin
        areq.start = !pend_reg &&
                     (state_reg inside {S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_DIV3, S_LIN});
        areq.op    = (state_reg inside {S_MUL1, S_MUL2}) ? OP_MUL : OP_DIV;
        case (state_reg)
            S_MUL1:
            begin
                aopa = NW'(hmag(hda));
                aopb = pa;
            end
            S_DIV1:
            begin
                aopa = prod_reg;
                aopb = d1;
            end
            S_MUL2:
            begin
                aopa = NW'(hmag(hdb));
                aopb = pb;
            end
            S_DIV2:
            begin
                aopa = prod_reg;
                aopb = d2;
            end
            S_DIV3:
            begin
                aopa = s_reg;
                aopb = d3;
            end
            S_LIN:
            begin
                aopa = up_reg ? NW'(hmag(hda)) : NW'(hmag(hdb));
                aopb = up_reg ? d1 : d2;
            end
            default:
            begin
                aopa = '0;
                aopb = '0;
            end
        endcase
    end

    psq_arith #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (areq),
        .opa    (aopa),
        .opb    (aopb),
        .done   (adone),
        .result (ares)
    );

    // parabolic candidate and linear fallback values
    always_comb
    begin
        qe   = EW'(q3_reg);
        cmag = (qe > CLAMP_E) ? CLAMP_E[62:0] : qe[62:0];
        qt   = sneg_reg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        q64  = 64'(q);
        ql64 = 64'(ql);
        qh64 = 64'(qh);
        newp = up_reg ? (q64 + qt) : (q64 - qt);
        quo  = ares[SW:0];
        lsgn = up_reg ? hda[SW] : hdb[SW];
        lq   = lsgn ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        newl = up_reg ? ((SW+2)'(q) + lq) : ((SW+2)'(q) - lq);
        est_ext = 64'(h_reg[2]);
    end

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        pos_next   = pos_reg;
        des_next   = des_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        k_next     = k_reg;
        up_next    = up_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        batch_next = batch_reg;
        prod_next  = prod_reg;
        t1_next    = t1_reg;
        t1neg_next = t1neg_reg;
        s_next     = s_reg;
        sneg_next  = sneg_reg;
        q3_next    = q3_reg;
        rw_next    = rw_reg;
        rv_next    = rv_reg;
        pend_next  = pend_reg;
        ins_pos    = '0;
        first      = 3'd4;
        dsum       = '0;

        if (areq.start)
            pend_next = 1'b1;
        if (adone)
            pend_next = 1'b0;
        if (rv_reg && !result_stall)
            rv_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next     = $signed(SW'($unsigned(sample_word.sample)));
                    batch_next = sample_word.batch_end;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (cnt_reg < 3'd5)
                begin
                    // sorted insert among the markers filled so far
                    for (int j = 0; j < 5; j++)
                        if (3'(j) < cnt_reg && h_reg[j] <= x_reg)
                            ins_pos = ins_pos + 3'd1;
                    for (int j = 0; j < 5; j++)
                    begin
                        if (3'(j) <= cnt_reg)
                        begin
                            if (3'(j) == ins_pos)
                                h_next[j] = x_reg;
                            else if (3'(j) > ins_pos)
                                h_next[j] = h_reg[(j > 0) ? j - 1 : 0];
                        end
                    end
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                        for (int i = 0; i < 3; i++)
                            des_next[i] = DPW'(start_reg[i]);
                    state_next = batch_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    if (x_reg < h_reg[0])
                    begin
                        h_next[0] = x_reg;
                        first = 3'd1;
                    end
                    else if (x_reg < h_reg[1])
                        first = 3'd1;
                    else if (x_reg < h_reg[2])
                        first = 3'd2;
                    else if (x_reg < h_reg[3])
                        first = 3'd3;
                    else
                    begin
                        if (x_reg >= h_reg[4])
                            h_next[4] = x_reg;
                        first = 3'd4;
                    end
                    for (int i = 1; i < 5; i++)
                    begin
                        if (3'(i) >= first)
                        begin
                            if (&pos_reg[i])
                                sat_next = 1'b1;
                            else
                                pos_next[i] = pos_reg[i] + PW'(1);
                        end
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        dsum = {1'b0, des_reg[i]} + (DPW+1)'(inc_reg[i]);
                        if (dsum[DPW])
                        begin
                            des_next[i] = '1;
                            sat_next    = 1'b1;
                        end
                        else
                            des_next[i] = dsum[DPW-1:0];
                    end
                    k_next     = 2'd1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (mvup || mvdn)
                begin
                    up_next    = mvup;
                    n_next     = mvup ? np[PW-1:0] : nm;
                    state_next = S_MUL1;
                end
                else if (k_reg == 2'd3)
                    state_next = batch_reg ? S_EMIT : S_IDLE;
                else
                    k_next = k_reg + 2'd1;
            end
            S_MUL1:
            begin
                if (adone)
                begin
                    prod_next  = ares;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (adone)
                begin
                    t1_next    = ares;
                    t1neg_next = hda[SW];
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (adone)
                begin
                    prod_next  = ares;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (adone)
                begin
                    // signed sum of the two terms in sign-magnitude form
                    if (t1neg_reg == hdb[SW])
                    begin
                        s_next    = t1_reg + ares;
                        sneg_next = t1neg_reg;
                    end
                    else if (t1_reg < ares)
                    begin
                        s_next    = ares - t1_reg;
                        sneg_next = hdb[SW];
                    end
                    else
                    begin
                        s_next    = t1_reg - ares;
                        sneg_next = t1neg_reg;
                    end
                    state_next = S_DIV3;
                end
            end
            S_DIV3:
            begin
                if (adone)
                begin
                    q3_next    = ares;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (ql64 < newp && newp < qh64)
                begin
                    h_next[kk]   = newp[SW-1:0];
                    pos_next[kk] = n_reg;
                    if (k_reg == 2'd3)
                        state_next = batch_reg ? S_EMIT : S_IDLE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_CHECK;
                    end
                end
                else
                    state_next = S_LIN;
            end
            S_LIN:
            begin
                if (adone)
                begin
                    h_next[kk]   = newl[SW-1:0];
                    pos_next[kk] = n_reg;
                    if (k_reg == 2'd3)
                        state_next = batch_reg ? S_EMIT : S_IDLE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_EMIT:
            begin
                if (!rv_reg || !result_stall)
                begin
                    rv_next           = 1'b1;
                    rw_next.estimate  = (cnt_reg == 3'd5) ? $signed(est_ext[31:0]) : '0;
                    rw_next.warmed_up = (cnt_reg == 3'd5);
                    rw_next.saturated = sat_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 5; i++)
                pos_reg[i] <= PW'(i);
            des_reg[0] <= DPW'(START_LOWER_RST);
            des_reg[1] <= DPW'(START_MIDDLE_RST);
            des_reg[2] <= DPW'(START_UPPER_RST);
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            k_reg     <= 2'd1;
            up_reg    <= 1'b0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            x_reg     <= '0;
            batch_reg <= 1'b0;
            prod_reg  <= '0;
            t1_reg    <= '0;
            t1neg_reg <= 1'b0;
            s_reg     <= '0;
            sneg_reg  <= 1'b0;
            q3_reg    <= '0;
            rv_reg    <= 1'b0;
            rw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            des_reg   <= des_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
            k_reg     <= k_next;
            up_reg    <= up_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            x_reg     <= x_next;
            batch_reg <= batch_next;
            prod_reg  <= prod_next;
            t1_reg    <= t1_next;
            t1neg_reg <= t1neg_next;
            s_reg     <= s_next;
            sneg_reg  <= sneg_next;
            q3_reg    <= q3_next;
            rv_reg    <= rv_next;
            rw_reg    <= rw_next;
        end
    end

    // marker heights are written before they are read
    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg[0]   <= INC_LOWER_RST;
            inc_reg[1]   <= INC_MIDDLE_RST;
            inc_reg[2]   <= INC_UPPER_RST;
            start_reg[0] <= START_LOWER_RST;
            start_reg[1] <= START_MIDDLE_RST;
            start_reg[2] <= START_UPPER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INC_LOWER:    inc_reg[0]   <= cfg_data[INC_W-1:0];
                REG_INC_MIDDLE:   inc_reg[1]   <= cfg_data[INC_W-1:0];
                REG_INC_UPPER:    inc_reg[2]   <= cfg_data[INC_W-1:0];
                REG_START_LOWER:  start_reg[0] <= cfg_data[START_W-1:0];
                REG_START_MIDDLE: start_reg[1] <= cfg_data[START_W-1:0];
                REG_START_UPPER:  start_reg[2] <= cfg_data[START_W-1:0];
                default:          ;
            endcase
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result_word  = rw_reg;

    `PSQ_ASSERT_IMPLY(a_warm_count, clk, rst_n, 1'b1, cnt_reg <= 3'd5)
    `PSQ_ASSERT_IMPLY(a_cold_estimate, clk, rst_n, rv_reg && !rw_reg.warmed_up, rw_reg.estimate == '0)
    `PSQ_ASSERT_IMPLY(a_done_pending, clk, rst_n, adone, pend_reg)
    `PSQ_ASSERT_IMPLY(a_pos_order, clk, rst_n, 1'b1, pos_reg[0] <= pos_reg[1] && pos_reg[1] <= pos_reg[2] && pos_reg[2] <= pos_reg[3] && pos_reg[3] <= pos_reg[4])
    `PSQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, sample_valid && !sample_stall, sample_stall)

endmodule
`default_nettype wire
